[src/scan_disk_scheduler_unit_assert.svh]
// Assertion macros for the scan disk scheduler
`ifndef SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define SDS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expr must never be true outside reset
`define SDS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define SDS_ASSERT(lbl, clk, rstn, prop, msg)
`define SDS_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[src/sds_pkg.sv]
package sds_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int CYL_WIDTH_DEF   = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int DISK_W     = 17;
    localparam int START_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_DISK_CYLINDERS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_CYLINDER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_UP       = 2'd2;

    localparam logic [DISK_W-1:0]  DISK_RESET  = 17'h10000;
    localparam logic [START_W-1:0] START_RESET = 16'h0000;
    localparam logic               SWEEP_RESET = 1'b1;

endpackage

[src/sds_alu.sv]
module sds_alu #(
    parameter int W = 16
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         gt,
    output logic [W-1:0] diff
);

    // shared compare / distance unit
    assign gt   = a > b;
    assign diff = gt ? (a - b) : (b - a);

endmodule

[src/sds_store.sv]
module sds_store #(
    parameter int DEPTH = 32,
    parameter int W     = 16,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/scan_disk_scheduler_unit.sv]
// SCAN (elevator) disk scheduler.
// Input stream: s_tdata carries one request cylinder, s_tlast marks the final
// request of a batch. Requests above the top cylinder are clamped on entry and
// each one is insertion-sorted into the request store as it arrives; at most
// QUEUE_DEPTH are kept, extra ones are dropped (a dropped last still schedules).
// Output stream: one word per visit in SCAN order; m_tuser flags the disk end
// turnaround, m_tlast the final visit, which also carries the total movement.
// Config port: cfg_we / cfg_addr / cfg_wdata, to be written only while idle by
// the user; the block does not enforce it. Placing a request takes a store read
// and a compare per shifted entry, bounded by the single store port and the
// shared compare unit. After the last request a split search reads and compares
// entries, then each result takes a store read, then an output register load,
// plus a step where the first sweep ends and the head turns to the disk end.
// s_tready is low from acceptance until the request is placed, and for the
// whole schedule. A stall on m_tready holds the output register and pauses
// the sequencer; nothing is lost. Synchronous active-low reset empties the
// queue, clears the output valid and restores the register defaults.
`include "scan_disk_scheduler_unit_assert.svh"

module scan_disk_scheduler_unit
    import sds_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CYL_WIDTH   = CYL_WIDTH_DEF,
    localparam int IN_W       = ((CYL_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * CYL_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // fields: request_cylinder
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // fields: visit_cylinder, total_movement
    output logic [OUT_W-1:0]      m_tdata,
    // fields: is_disk_end
    output logic                  m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW    = (DISK_W > CYL_WIDTH) ? DISK_W : CYL_WIDTH;
    localparam int SUM_W = CYL_WIDTH + 1;

    typedef enum logic [6:0] {
        ST_LOAD      = 7'b0000001,
        ST_INS_RD    = 7'b0000010,
        ST_INS_CMP   = 7'b0000100,
        ST_SPLIT_RD  = 7'b0001000,
        ST_SPLIT_CMP = 7'b0010000,
        ST_EMIT_RD   = 7'b0100000,
        ST_EMIT_OUT  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        LEG_FIRST  = 3'b001,
        LEG_END    = 3'b010,
        LEG_SECOND = 3'b100
    } leg_t;

    state_t                 state_reg, state_next;
    leg_t                   leg_reg, leg_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       split_reg, split_next;
    logic [CYL_WIDTH-1:0]   ins_val_reg, ins_val_next;
    logic [CYL_WIDTH-1:0]   head_reg, head_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   last_req_reg, last_req_next;
    logic                   cand_end_reg, cand_end_next;
    logic                   cand_last_reg, cand_last_next;

    logic                   m_valid_reg, m_valid_next;
    logic [CYL_WIDTH-1:0]   m_visit_reg, m_visit_next;
    logic [SUM_W-1:0]       m_total_reg, m_total_next;
    logic                   m_end_reg, m_end_next;
    logic                   m_last_reg, m_last_next;

    logic [DISK_W-1:0]      disk_reg;
    logic [START_W-1:0]     start_reg;
    logic                   sweep_reg;

    logic [TW-1:0]          disk_ext, disk_dec, cyl_max_ext;
    logic [CYL_WIDTH-1:0]   top_cyl, start_eff, start_clamp, req_in, req_clamp;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [CYL_WIDTH-1:0]   mem_wdata, mem_rdata;

    logic [CYL_WIDTH-1:0]   alu_a, alu_b, alu_diff;
    logic                   alu_gt;

    logic                   accept, out_free, asc, start_sched;
    logic [CNT_W-1:0]       idx_inc, idx_dec;
    logic [CYL_WIDTH-1:0]   emit_cyl;

    // top cylinder: disk size minus one, zero for an empty disk, saturated
    assign disk_ext    = TW'(disk_reg);
    assign disk_dec    = disk_ext - TW'(1);
    assign cyl_max_ext = TW'({CYL_WIDTH{1'b1}});
    assign top_cyl     = (disk_reg == '0) ? '0 :
                         (disk_dec > cyl_max_ext) ? {CYL_WIDTH{1'b1}} :
                         disk_dec[CYL_WIDTH-1:0];

    assign start_eff   = CYL_WIDTH'(start_reg);
    assign start_clamp = (start_eff > top_cyl) ? top_cyl : start_eff;
    assign req_in      = s_tdata[CYL_WIDTH-1:0];
    assign req_clamp   = (req_in > top_cyl) ? top_cyl : req_in;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign asc      = (leg_reg == LEG_FIRST) ? sweep_reg : !sweep_reg;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign emit_cyl = cand_end_reg ? (sweep_reg ? top_cyl : '0) : mem_rdata;

    // one compare/distance unit shared by insert, split search and emission
    assign alu_a = (state_reg == ST_EMIT_OUT) ? emit_cyl : mem_rdata;
    assign alu_b = (state_reg == ST_INS_CMP) ? ins_val_reg : head_reg;

    sds_alu #(
        .W (CYL_WIDTH)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .gt   (alu_gt),
        .diff (alu_diff)
    );

    sds_store #(
        .DEPTH (QUEUE_DEPTH),
        .W     (CYL_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        leg_next       = leg_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        split_next     = split_reg;
        ins_val_next   = ins_val_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        last_req_next  = last_req_reg;
        cand_end_next  = cand_end_reg;
        cand_last_next = cand_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_visit_next   = m_visit_reg;
        m_total_next   = m_total_reg;
        m_end_next     = m_end_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = ins_val_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[AW-1:0];
        start_sched    = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    last_req_next = s_tlast;
                    if (count_reg != CNT_W'(QUEUE_DEPTH)) begin
                        ins_val_next = req_clamp;
                        idx_next     = count_reg;
                        state_next   = ST_INS_RD;
                    end else if (s_tlast) begin
                        start_sched = 1'b1;
                    end
                end
            end
            ST_INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (last_req_reg) begin
                        start_sched = 1'b1;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_dec[AW-1:0];
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                mem_we = 1'b1;
                if (alu_gt) begin
                    // shift the larger entry up one slot
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_dec;
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (last_req_reg) begin
                        start_sched = 1'b1;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_SPLIT_RD: begin
                if (idx_reg == count_reg) begin
                    split_next = count_reg;
                    idx_next   = count_reg;
                    leg_next   = LEG_FIRST;
                    state_next = ST_EMIT_RD;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_SPLIT_CMP;
                end
            end
            ST_SPLIT_CMP: begin
                if (alu_gt) begin
                    split_next = idx_reg;
                    leg_next   = LEG_FIRST;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SPLIT_RD;
                end
            end
            ST_EMIT_RD: begin
                case (leg_reg)
                    LEG_END: begin
                        cand_end_next  = 1'b1;
                        cand_last_next = sweep_reg ? (split_reg == '0)
                                                   : (split_reg == count_reg);
                        state_next     = ST_EMIT_OUT;
                    end
                    LEG_FIRST, LEG_SECOND: begin
                        if (asc ? (idx_reg == count_reg) : (idx_reg == '0)) begin
                            if (leg_reg == LEG_FIRST) begin
                                leg_next = LEG_END;
                                idx_next = split_reg;
                            end else begin
                                count_next = '0;
                                state_next = ST_LOAD;
                            end
                        end else begin
                            mem_re         = 1'b1;
                            mem_raddr      = asc ? idx_reg[AW-1:0] : idx_dec[AW-1:0];
                            cand_end_next  = 1'b0;
                            cand_last_next = (leg_reg == LEG_SECOND) &&
                                             (asc ? (idx_inc == count_reg)
                                                  : (idx_reg == CNT_W'(1)));
                            state_next     = ST_EMIT_OUT;
                        end
                    end
                    default: begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                endcase
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_visit_next = emit_cyl;
                    m_end_next   = cand_end_reg;
                    m_last_next  = cand_last_reg;
                    m_total_next = cand_last_reg ? (sum_reg + SUM_W'(alu_diff)) : '0;
                    head_next    = emit_cyl;
                    sum_next     = sum_reg + SUM_W'(alu_diff);
                    if (cand_last_reg) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else if (cand_end_reg) begin
                        leg_next   = LEG_SECOND;
                        state_next = ST_EMIT_RD;
                    end else begin
                        idx_next   = asc ? idx_inc : idx_dec;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (start_sched) begin
            head_next  = start_clamp;
            sum_next   = '0;
            idx_next   = '0;
            state_next = ST_SPLIT_RD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            disk_reg    <= DISK_RESET;
            start_reg   <= START_RESET;
            sweep_reg   <= SWEEP_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DISK_CYLINDERS: disk_reg  <= cfg_wdata[DISK_W-1:0];
                    CFG_START_CYLINDER: start_reg <= cfg_wdata[START_W-1:0];
                    CFG_SWEEP_UP:       sweep_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        leg_reg       <= leg_next;
        idx_reg       <= idx_next;
        split_reg     <= split_next;
        ins_val_reg   <= ins_val_next;
        head_reg      <= head_next;
        sum_reg       <= sum_next;
        last_req_reg  <= last_req_next;
        cand_end_reg  <= cand_end_next;
        cand_last_reg <= cand_last_next;
        m_visit_reg   <= m_visit_next;
        m_total_reg   <= m_total_next;
        m_end_reg     <= m_end_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_total_reg, m_visit_reg});
    assign m_tuser  = m_end_reg;
    assign m_tlast  = m_last_reg;

    `SDS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `SDS_ASSERT(a_ins_idx, aclk, aresetn, (state_reg == ST_INS_CMP) |-> ((idx_reg != '0) && (idx_reg <= count_reg)), "insert index out of range")
    `SDS_ASSERT(a_batch_done, aclk, aresetn, ((state_reg == ST_EMIT_OUT) && out_free && cand_last_reg) |=> ((state_reg == ST_LOAD) && (count_reg == '0)), "batch did not close")
    `SDS_ASSERT_NEVER(a_total_last, aclk, aresetn, m_valid_reg && !m_last_reg && (m_total_reg != '0), "movement on non-final word")

endmodule
